// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: hw/rtl/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// types, codes and helpers of the notice slot scheduler
// ----------------------------------------------------------------------------
package nss_pkg;

    localparam int SLOTS_DEF = 8;
    localparam logic [3:0] MAX_WAIT_RESET = 4'd6;

    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] OP_POST    = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_ACK     = 3'd2;
    localparam logic [2:0] OP_SNOOZE  = 3'd3;
    localparam logic [2:0] OP_RELEASE = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_GONE    = 2'd3;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_QUEUED,
        PH_ACTIVE,
        PH_SNOOZED
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] id;
        logic [31:0] owner;
        logic [31:0] key;
        logic [63:0] order;
        logic [63:0] expiry;
        logic [63:0] wake;
    } t_slot;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] n);
        logic [32:0] s;
        s = {1'b0, a} + {31'b0, n};
        sat_add = s[32] ? U32_MAX : s[31:0];
    endfunction

endpackage

// File: hw/rtl/notice_slot_scheduler_core.sv
// ----------------------------------------------------------------------------
// notice_slot_scheduler_core
// table of notice slots kept in one ram, walked by a slot sequencer
//
//  channel   direction  handshake                 payload
//  request   in         i_valid / o_stall         i_op, i_owner, i_dedup_key,
//                                                 i_notice_id, i_time_value
//  result    out        o_valid / i_stall         o_status .. o_revision
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (max_waiting)
//
//  each slot visit is a ram read state followed by an evaluate state
//  post, cancel, ack, snooze and release run a table pass and then a reschedule pass,
//  tick runs wake, pick and reschedule passes; duplicate, full, gone or wrong phase
//  end after the first pass; early tick, owner zero or unused op skip every pass
//  order counter saturation inserts a renumbering of all slot orders on a post or a tick
//  reset clears valid bits per slot, no clearing pass
//  a finished result waits in the output register while the next request runs,
//  a second finished result holds the sequencer until the first is taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module notice_slot_scheduler_core #(
    parameter int SLOTS = nss_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_owner,
    input  logic [31:0] i_dedup_key,
    input  logic [31:0] i_notice_id,
    input  logic [63:0] i_time_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_id,
    output logic [63:0] o_next_deadline,
    output logic        o_active_valid,
    output logic [31:0] o_active_id,
    output logic [31:0] o_active_owner,
    output logic        o_changed,
    output logic [31:0] o_revision,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = $bits(nss_pkg::t_slot);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_END, S_PWR, S_FIN} t_state;
    typedef enum logic [3:0] {
        P_POST, P_FIND, P_REL, P_TWAKE, P_TPICK, P_RESCH, P_RN_OUT, P_RN_IN, P_RN_WR
    } t_pass;

    t_state         r_state;
    t_pass          r_pass;
    t_pass          r_ret_pass;
    logic           r_ret_wr;
    logic [IW-1:0]  r_k, r_ri, r_rj;
    logic [CW-1:0]  r_rn_cnt, r_rn_tot;
    logic [63:0]    r_rn_oi;
    logic           r_rn_nf;
    logic [CW-1:0]  r_rank [SLOTS];
    logic [SLOTS-1:0] r_valid;

    logic [2:0]     r_op;
    logic [31:0]    r_owner, r_key, r_nid;
    logic [63:0]    r_tv;

    logic           r_found;
    logic [IW-1:0]  r_fidx;
    nss_pkg::t_slot r_frec;
    logic [CW-1:0]  r_wait;
    logic           r_free_found;
    logic [IW-1:0]  r_free_idx;
    logic           r_act_seen, r_que_seen;
    logic [63:0]    r_due;

    logic [31:0]    r_last_id;
    logic [63:0]    r_ctr;
    logic [63:0]    r_deadline;
    logic           r_act_valid;
    logic [31:0]    r_act_id, r_act_owner;
    logic           r_changed;
    logic [31:0]    r_rev;
    logic [3:0]     r_max_wait;
    logic [1:0]     r_status;
    logic [31:0]    r_rid;

    logic           r_out_valid;
    logic [1:0]     r_o_status;
    logic [31:0]    r_o_rid;
    logic [63:0]    r_o_deadline;
    logic           r_o_act_valid;
    logic [31:0]    r_o_act_id, r_o_act_owner;
    logic           r_o_changed;
    logic [31:0]    r_o_rev;

    logic [IW-1:0]  w_idx;
    logic [SW-1:0]  w_raw;
    nss_pkg::t_slot w_rec;
    logic           w_we;
    logic [IW-1:0]  w_wa;
    nss_pkg::t_slot w_wd;
    logic           w_ctr_max;
    logic           w_wait_full;
    logic           w_t_wake, w_t_exp;
    nss_pkg::t_phase w_t_ph;
    logic [1:0]     w_marks;
    logic [1:0]     w_find_st;
    logic           w_find_snz, w_find_clr;
    logic           w_promote;
    logic [63:0]    w_due;
    logic [CW-1:0]  w_rn_cnt;

    nss_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wa),
        .i_wdata (w_wd),
        .i_re    (r_state == S_RD),
        .i_raddr (w_idx),
        .o_rdata (w_raw)
    );

    always_comb begin
        case (r_pass)
            P_RN_OUT, P_RN_WR: w_idx = r_ri;
            P_RN_IN:           w_idx = r_rj;
            default:           w_idx = r_k;
        endcase
        w_rec = r_valid[w_idx] ? nss_pkg::t_slot'(w_raw) : '0;
        w_ctr_max = (r_ctr == nss_pkg::U64_MAX);
        w_wait_full = (32'(r_wait) >= 32'(r_max_wait));

        // tick wake and expiry for one slot
        w_t_wake = (w_rec.phase == nss_pkg::PH_SNOOZED) && (r_tv >= w_rec.wake);
        w_t_ph = w_t_wake ? nss_pkg::PH_QUEUED : w_rec.phase;
        w_t_exp = ((w_t_ph == nss_pkg::PH_QUEUED) || (w_t_ph == nss_pkg::PH_ACTIVE))
                  && (w_rec.expiry != 64'd0) && (r_tv >= w_rec.expiry);

        // cancel, ack and snooze decision
        w_find_snz = 1'b0;
        w_find_clr = 1'b0;
        if (!r_found) begin
            w_find_st = nss_pkg::ST_GONE;
        end else if (r_op == nss_pkg::OP_SNOOZE) begin
            if (r_frec.phase != nss_pkg::PH_ACTIVE || r_tv == 64'd0
                || r_tv == nss_pkg::U64_MAX) begin
                w_find_st = nss_pkg::ST_INVALID;
            end else if (w_wait_full) begin
                w_find_st = nss_pkg::ST_FULL;
            end else begin
                w_find_st = nss_pkg::ST_OK;
                w_find_snz = 1'b1;
            end
        end else if (r_op == nss_pkg::OP_ACK && r_frec.phase != nss_pkg::PH_ACTIVE) begin
            w_find_st = nss_pkg::ST_INVALID;
        end else begin
            w_find_st = nss_pkg::ST_OK;
            w_find_clr = 1'b1;
        end
        w_promote = !r_act_seen && r_found;

        // deadline accumulation
        w_due = r_due;
        if (w_rec.phase == nss_pkg::PH_SNOOZED && w_rec.wake < w_due) begin
            w_due = w_rec.wake;
        end
        if ((w_rec.phase == nss_pkg::PH_ACTIVE || w_rec.phase == nss_pkg::PH_QUEUED)
            && w_rec.expiry != 64'd0 && w_rec.expiry < w_due) begin
            w_due = w_rec.expiry;
        end

        w_rn_cnt = r_rn_cnt + CW'(r_valid[r_rj] && (w_rec.order < r_rn_oi));

        w_we = 1'b0;
        w_wa = w_idx;
        w_wd = w_rec;
        w_marks = 2'd0;
        case (r_state)
            S_EV: begin
                case (r_pass)
                    P_REL: begin
                        if (r_valid[r_k] && w_rec.owner == r_owner) begin
                            w_marks = 2'd1;
                        end
                    end
                    P_TWAKE: begin
                        if (!(w_t_wake && w_ctr_max)) begin
                            w_marks = {1'b0, w_t_wake} + {1'b0, w_t_exp};
                            if (w_t_wake && !w_t_exp) begin
                                w_we = 1'b1;
                                w_wd.phase = nss_pkg::PH_QUEUED;
                                w_wd.order = r_ctr + 64'd1;
                            end
                        end
                    end
                    P_RN_WR: begin
                        w_we = r_valid[r_ri];
                        w_wd.order = 64'(r_rank[r_ri]);
                    end
                    default: begin
                    end
                endcase
            end
            S_END: begin
                case (r_pass)
                    P_FIND: begin
                        w_wa = r_fidx;
                        w_wd = r_frec;
                        w_wd.phase = nss_pkg::PH_SNOOZED;
                        w_wd.wake = r_tv;
                        w_we = w_find_snz;
                        w_marks = {1'b0, w_find_snz | w_find_clr};
                    end
                    P_TPICK: begin
                        w_wa = r_fidx;
                        w_wd = r_frec;
                        w_wd.phase = nss_pkg::PH_ACTIVE;
                        w_we = w_promote;
                        w_marks = {1'b0, w_promote};
                    end
                    default: begin
                    end
                endcase
            end
            S_PWR: begin
                w_wa = r_free_idx;
                w_wd.phase = nss_pkg::PH_QUEUED;
                w_wd.id = r_last_id + 32'd1;
                w_wd.owner = r_owner;
                w_wd.key = r_key;
                w_wd.order = r_ctr + 64'd1;
                w_wd.expiry = r_tv;
                w_wd.wake = 64'd0;
                w_we = !w_ctr_max;
                w_marks = {1'b0, !w_ctr_max};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass <= P_POST;
            r_valid <= '0;
            r_last_id <= 32'd0;
            r_ctr <= 64'd0;
            r_deadline <= 64'd0;
            r_act_valid <= 1'b0;
            r_act_id <= 32'd0;
            r_act_owner <= 32'd0;
            r_changed <= 1'b0;
            r_rev <= 32'd0;
            r_max_wait <= nss_pkg::MAX_WAIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_wait <= i_cfg_data;
            end
            if (w_marks != 2'd0) begin
                r_changed <= 1'b1;
                r_rev <= nss_pkg::sat_add(r_rev, w_marks);
            end
            if (r_out_valid && !i_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_op;
                        r_owner <= i_owner;
                        r_key <= i_dedup_key;
                        r_nid <= i_notice_id;
                        r_tv <= i_time_value;
                        r_k <= '0;
                        r_found <= 1'b0;
                        r_wait <= '0;
                        r_free_found <= 1'b0;
                        r_act_seen <= 1'b0;
                        r_que_seen <= 1'b0;
                        r_due <= nss_pkg::U64_MAX;
                        r_status <= nss_pkg::ST_OK;
                        r_rid <= 32'd0;
                        r_state <= S_RD;
                        case (i_op)
                            nss_pkg::OP_POST: begin
                                r_pass <= P_POST;
                                if (i_owner == 32'd0) begin
                                    r_status <= nss_pkg::ST_INVALID;
                                    r_state <= S_FIN;
                                end
                            end
                            nss_pkg::OP_CANCEL, nss_pkg::OP_ACK, nss_pkg::OP_SNOOZE: begin
                                r_pass <= P_FIND;
                            end
                            nss_pkg::OP_RELEASE: begin
                                r_pass <= P_REL;
                                if (i_owner == 32'd0) begin
                                    r_status <= nss_pkg::ST_INVALID;
                                    r_state <= S_FIN;
                                end
                            end
                            nss_pkg::OP_TICK: begin
                                r_pass <= P_TWAKE;
                                if (i_time_value < r_deadline) begin
                                    r_state <= S_FIN;
                                end
                            end
                            default: begin
                                r_status <= nss_pkg::ST_INVALID;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (r_k == LAST) begin
                        r_state <= S_END;
                    end else begin
                        r_k <= r_k + IW'(1);
                        r_state <= S_RD;
                    end
                    case (r_pass)
                        P_POST: begin
                            if (r_valid[r_k]) begin
                                if (r_key != 32'd0 && w_rec.owner == r_owner
                                    && w_rec.key == r_key && !r_found) begin
                                    r_found <= 1'b1;
                                    r_frec <= w_rec;
                                end
                                if (w_rec.phase == nss_pkg::PH_QUEUED
                                    || w_rec.phase == nss_pkg::PH_SNOOZED) begin
                                    r_wait <= r_wait + CW'(1);
                                end
                            end else if (!r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx <= r_k;
                            end
                        end
                        P_FIND: begin
                            if (r_valid[r_k]) begin
                                if (r_nid != 32'd0 && w_rec.id == r_nid
                                    && w_rec.owner == r_owner && !r_found) begin
                                    r_found <= 1'b1;
                                    r_fidx <= r_k;
                                    r_frec <= w_rec;
                                end
                                if (w_rec.phase == nss_pkg::PH_QUEUED
                                    || w_rec.phase == nss_pkg::PH_SNOOZED) begin
                                    r_wait <= r_wait + CW'(1);
                                end
                            end
                        end
                        P_REL: begin
                            if (r_valid[r_k] && w_rec.owner == r_owner) begin
                                r_valid[r_k] <= 1'b0;
                            end
                        end
                        P_TWAKE: begin
                            if (w_t_wake && w_ctr_max) begin
                                // renumber orders, then revisit this slot
                                r_k <= r_k;
                                r_ret_pass <= P_TWAKE;
                                r_ret_wr <= 1'b0;
                                r_pass <= P_RN_OUT;
                                r_ri <= '0;
                                r_rn_tot <= '0;
                                r_state <= S_RD;
                            end else begin
                                if (w_t_wake) begin
                                    r_ctr <= r_ctr + 64'd1;
                                end
                                if (w_t_exp) begin
                                    r_valid[r_k] <= 1'b0;
                                end
                            end
                        end
                        P_TPICK: begin
                            if (w_rec.phase == nss_pkg::PH_ACTIVE) begin
                                r_act_seen <= 1'b1;
                            end
                            if (w_rec.phase == nss_pkg::PH_QUEUED
                                && (!r_found || w_rec.order < r_frec.order)) begin
                                r_found <= 1'b1;
                                r_fidx <= r_k;
                                r_frec <= w_rec;
                            end
                        end
                        P_RESCH: begin
                            if (w_rec.phase == nss_pkg::PH_ACTIVE) begin
                                r_act_seen <= 1'b1;
                                r_frec <= w_rec;
                            end
                            if (w_rec.phase == nss_pkg::PH_QUEUED) begin
                                r_que_seen <= 1'b1;
                            end
                            r_due <= w_due;
                        end
                        P_RN_OUT: begin
                            r_k <= r_k;
                            r_rn_oi <= w_rec.order;
                            r_rn_nf <= r_valid[r_ri];
                            r_rj <= '0;
                            r_rn_cnt <= '0;
                            r_pass <= P_RN_IN;
                            r_state <= S_RD;
                        end
                        P_RN_IN: begin
                            r_k <= r_k;
                            r_state <= S_RD;
                            r_rn_cnt <= w_rn_cnt;
                            if (r_rj == LAST) begin
                                r_rank[r_ri] <= r_rn_nf ? w_rn_cnt + CW'(1) : '0;
                                r_rn_tot <= r_rn_tot + CW'(r_rn_nf);
                                if (r_ri == LAST) begin
                                    r_ri <= '0;
                                    r_pass <= P_RN_WR;
                                end else begin
                                    r_ri <= r_ri + IW'(1);
                                    r_pass <= P_RN_OUT;
                                end
                            end else begin
                                r_rj <= r_rj + IW'(1);
                            end
                        end
                        P_RN_WR: begin
                            r_k <= r_k;
                            if (r_ri == LAST) begin
                                r_ctr <= 64'(r_rn_tot);
                                r_pass <= r_ret_pass;
                                r_state <= r_ret_wr ? S_PWR : S_RD;
                            end else begin
                                r_ri <= r_ri + IW'(1);
                                r_state <= S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_END: begin
                    r_k <= '0;
                    r_act_seen <= 1'b0;
                    r_que_seen <= 1'b0;
                    r_due <= nss_pkg::U64_MAX;
                    r_pass <= P_RESCH;
                    r_state <= S_RD;
                    case (r_pass)
                        P_POST: begin
                            if (r_found) begin
                                r_rid <= r_frec.id;
                                r_state <= S_FIN;
                            end else if (w_wait_full || r_last_id == nss_pkg::U32_MAX
                                         || !r_free_found) begin
                                r_status <= nss_pkg::ST_FULL;
                                r_state <= S_FIN;
                            end else begin
                                r_pass <= P_POST;
                                r_state <= S_PWR;
                            end
                        end
                        P_FIND: begin
                            r_status <= w_find_st;
                            if (w_find_clr) begin
                                r_valid[r_fidx] <= 1'b0;
                            end
                            if (!(w_find_snz || w_find_clr)) begin
                                r_state <= S_FIN;
                            end
                        end
                        P_TWAKE: begin
                            r_found <= 1'b0;
                            r_pass <= P_TPICK;
                        end
                        P_RESCH: begin
                            r_deadline <= (!r_act_seen && r_que_seen) ? 64'd0 : r_due;
                            r_act_valid <= r_act_seen;
                            r_act_id <= r_act_seen ? r_frec.id : 32'd0;
                            r_act_owner <= r_act_seen ? r_frec.owner : 32'd0;
                            r_state <= S_FIN;
                        end
                        default: begin
                        end
                    endcase
                end
                S_PWR: begin
                    if (w_ctr_max) begin
                        r_ret_pass <= P_POST;
                        r_ret_wr <= 1'b1;
                        r_pass <= P_RN_OUT;
                        r_ri <= '0;
                        r_rn_tot <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_ctr <= r_ctr + 64'd1;
                        r_last_id <= r_last_id + 32'd1;
                        r_rid <= r_last_id + 32'd1;
                        r_valid[r_free_idx] <= 1'b1;
                        r_k <= '0;
                        r_act_seen <= 1'b0;
                        r_que_seen <= 1'b0;
                        r_due <= nss_pkg::U64_MAX;
                        r_pass <= P_RESCH;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_status <= r_status;
                        r_o_rid <= r_rid;
                        r_o_deadline <= r_deadline;
                        r_o_act_valid <= r_act_valid;
                        r_o_act_id <= r_act_id;
                        r_o_act_owner <= r_act_owner;
                        r_o_changed <= r_changed;
                        r_o_rev <= r_rev;
                        r_changed <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_out_valid;
    assign o_status = r_o_status;
    assign o_result_id = r_o_rid;
    assign o_next_deadline = r_o_deadline;
    assign o_active_valid = r_o_act_valid;
    assign o_active_id = r_o_act_id;
    assign o_active_owner = r_o_act_owner;
    assign o_changed = r_o_changed;
    assign o_revision = r_o_rev;

    `ASSERT_CLK(a_no_write_idle, r_state == S_IDLE |-> !w_we, "slot write while idle")
    `ASSERT_NEXT(a_accept_busy, i_valid && !o_stall, r_state != S_IDLE, "request lost")
    `ASSERT_NEXT(a_rev_monotonic, r_state != S_IDLE, r_rev >= $past(r_rev), "revision fell")
    `ASSERT_CLK(a_active_owner, !r_act_valid |-> r_act_id == 32'd0, "stale active id")

endmodule

// File: hw/rtl/nss_ram.sv
// ----------------------------------------------------------------------------
// nss_ram
// single write port, single registered read port ram
// ----------------------------------------------------------------------------
module nss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule
